// ===== src/sha1_pkg.sv =====
// Shared types and constants for the SHA-1 digest block.
`default_nettype none
package sha1_pkg;

   localparam logic [31:0] H_INIT0 = 32'h67452301;
   localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
   localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
   localparam logic [31:0] H_INIT3 = 32'h10325476;
   localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [5:0] LEN_FILL   = 6'd56;
   localparam logic [5:0] FULL_FILL  = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'd4;

   typedef enum logic [1:0] {
      SRC_MSG   = 2'd0,
      SRC_PAD80 = 2'd1,
      SRC_ZERO  = 2'd2,
      SRC_LEN   = 2'd3
   } byte_src_type;

   typedef struct packed {
      logic         load_in;
      logic         put;
      byte_src_type byte_src;
      logic [2:0]   byte_idx;
      logic         count;
      logic         load_vars;
      logic         round;
      logic [6:0]   rnd;
      logic         add_chain;
      logic         clear_msg;
      logic [2:0]   out_idx;
   } sha1_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic [2:0] nbytes;
      logic       last;
   } sha1_status_type;

endpackage
`default_nettype wire

// ===== src/sha1_if.sv =====
// Valid/ready channel interfaces for message words and digest words.
`default_nettype none
interface sha1_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        last_word;
   modport source (output valid, data_word, valid_bytes, last_word, input ready);
   modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_result;
   modport source (output valid, digest_word, word_index, last_result, input ready);
   modport sink (input valid, digest_word, word_index, last_result, output ready);
endinterface
`default_nettype wire

// ===== src/sha1_datapath.sv =====
// SHA-1 datapath: byte packing, schedule window, round logic and chaining values.
`default_nettype none
module sha1_datapath import sha1_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire sha1_cmd_type    cmd,
   input  wire logic [31:0]     in_data,
   input  wire logic [2:0]      in_bytes,
   input  wire logic            in_last,
   output sha1_status_type      status,
   output logic [31:0]          digest_word
);

   logic [31:0] data_ff;
   logic [2:0]  nbytes_ff;
   logic        last_ff;
   logic [5:0]  fill_ff;
   logic [31:0] acc_ff;
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [5];
   logic [31:0] v_ff [5];
   logic [63:0] bitcnt_ff;

   logic [7:0]  byte_val;
   logic [4:0]  pos_sh;
   logic [31:0] merged;
   logic [31:0] w_new;
   logic [31:0] w_t;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] tmp;
   logic        push_word;

   always_comb begin
      case (cmd.byte_src)
         SRC_MSG:   byte_val = 8'(data_ff >> {~cmd.byte_idx[1:0], 3'b000});
         SRC_PAD80: byte_val = 8'h80;
         SRC_LEN:   byte_val = 8'(bitcnt_ff >> {~cmd.byte_idx, 3'b000});
         default:   byte_val = 8'h00;
      endcase
   end

   // byte lands at position fill[1:0], first byte in the top lane
   assign pos_sh    = {~fill_ff[1:0], 3'b000};
   assign merged    = (acc_ff & ~(32'h0000_00FF << pos_sh)) | (32'(byte_val) << pos_sh);
   assign push_word = cmd.put && (fill_ff[1:0] == 2'd3);

   // w_ff[0] holds W[t-16] once the window has turned over
   always_comb begin
      w_new = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_new[30:0], w_new[31]};
      w_t   = (cmd.rnd < 7'd16) ? w_ff[0] : w_new;
   end

   always_comb begin
      if (cmd.rnd < 7'd20) begin
         f_val = (v_ff[1] & v_ff[2]) | (~v_ff[1] & v_ff[3]);
         k_val = K_ROUND0;
      end else if (cmd.rnd < 7'd40) begin
         f_val = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k_val = K_ROUND1;
      end else if (cmd.rnd < 7'd60) begin
         f_val = (v_ff[1] & v_ff[2]) | (v_ff[1] & v_ff[3]) | (v_ff[2] & v_ff[3]);
         k_val = K_ROUND2;
      end else begin
         f_val = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k_val = K_ROUND3;
      end
      tmp = {v_ff[0][26:0], v_ff[0][31:27]} + f_val + v_ff[4] + w_t + k_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         data_ff   <= in_data;
         nbytes_ff <= (in_bytes > 3'd4) ? 3'd4 : in_bytes;
         last_ff   <= in_last;
      end
      if (cmd.put) begin
         acc_ff <= merged;
      end
      if (push_word || cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= cmd.round ? w_t : merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         bitcnt_ff <= '0;
         h_ff[0]   <= H_INIT0;
         h_ff[1]   <= H_INIT1;
         h_ff[2]   <= H_INIT2;
         h_ff[3]   <= H_INIT3;
         h_ff[4]   <= H_INIT4;
         for (int i = 0; i < 5; i++) begin
            v_ff[i] <= '0;
         end
      end else begin
         if (cmd.put) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.count) begin
            bitcnt_ff <= bitcnt_ff + 64'd8;
         end
         if (cmd.load_vars) begin
            for (int i = 0; i < 5; i++) begin
               v_ff[i] <= h_ff[i];
            end
         end else if (cmd.round) begin
            v_ff[0] <= tmp;
            v_ff[1] <= v_ff[0];
            v_ff[2] <= {v_ff[1][1:0], v_ff[1][31:2]};
            v_ff[3] <= v_ff[2];
            v_ff[4] <= v_ff[3];
         end
         if (cmd.clear_msg) begin
            bitcnt_ff <= '0;
            fill_ff   <= '0;
            h_ff[0]   <= H_INIT0;
            h_ff[1]   <= H_INIT1;
            h_ff[2]   <= H_INIT2;
            h_ff[3]   <= H_INIT3;
            h_ff[4]   <= H_INIT4;
         end else if (cmd.add_chain) begin
            for (int i = 0; i < 5; i++) begin
               h_ff[i] <= h_ff[i] + v_ff[i];
            end
         end
      end
   end

   always_comb begin
      case (cmd.out_idx)
         3'd0:    digest_word = h_ff[0];
         3'd1:    digest_word = h_ff[1];
         3'd2:    digest_word = h_ff[2];
         3'd3:    digest_word = h_ff[3];
         default: digest_word = h_ff[4];
      endcase
   end

   assign status.fill   = fill_ff;
   assign status.nbytes = nbytes_ff;
   assign status.last   = last_ff;

endmodule
`default_nettype wire

// ===== src/sha1_ctrl.sv =====
// SHA-1 controller: sequences bytes, padding, rounds and digest output.
`default_nettype none
module sha1_ctrl import sha1_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire sha1_status_type status,
   output sha1_cmd_type         cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MSG   = 8'b0000_0010,
      ST_PAD   = 8'b0000_0100,
      ST_LEN   = 8'b0000_1000,
      ST_LOADV = 8'b0001_0000,
      ST_ROUND = 8'b0010_0000,
      ST_ADD   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic [2:0] idx_ff, idx_in;
   logic [6:0] rnd_ff, rnd_in;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      idx_in    = idx_ff;
      rnd_in    = rnd_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.byte_src = SRC_ZERO;
      cmd.byte_idx = idx_ff;
      cmd.rnd      = rnd_ff;
      cmd.out_idx  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               idx_in      = '0;
               state_in    = ST_MSG;
            end
         end
         ST_MSG: begin
            if (idx_ff < status.nbytes) begin
               cmd.put      = 1'b1;
               cmd.byte_src = SRC_MSG;
               cmd.count    = 1'b1;
               idx_in       = idx_ff + 3'd1;
               if (status.fill == FULL_FILL) begin
                  ret_in   = ST_MSG;
                  state_in = ST_LOADV;
               end
            end else if (status.last) begin
               cmd.put      = 1'b1;
               cmd.byte_src = SRC_PAD80;
               if (status.fill == FULL_FILL) begin
                  ret_in   = ST_PAD;
                  state_in = ST_LOADV;
               end else begin
                  state_in = ST_PAD;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (status.fill == LEN_FILL) begin
               idx_in   = '0;
               state_in = ST_LEN;
            end else begin
               cmd.put = 1'b1;
               if (status.fill == FULL_FILL) begin
                  ret_in   = ST_PAD;
                  state_in = ST_LOADV;
               end
            end
         end
         ST_LEN: begin
            cmd.put      = 1'b1;
            cmd.byte_src = SRC_LEN;
            idx_in       = idx_ff + 3'd1;
            if (idx_ff == 3'd7) begin
               ret_in   = ST_OUT;
               state_in = ST_LOADV;
            end
         end
         ST_LOADV: begin
            cmd.load_vars = 1'b1;
            rnd_in        = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            idx_in        = (ret_ff == ST_OUT) ? 3'd0 : idx_ff;
            state_in      = ret_ff;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_WORD_IDX) begin
                  cmd.clear_msg = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         idx_ff   <= '0;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
         rnd_ff   <= rnd_in;
      end
   end

   round_range_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> rnd_ff <= LAST_ROUND)
      else $error("round index past last round");

   round_exit_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && rnd_ff == LAST_ROUND |=> state_ff == ST_ADD)
      else $error("compression did not end after last round");

   out_idx_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> idx_ff <= LAST_WORD_IDX)
      else $error("digest word index out of range");

   len_fill_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAD && status.fill == LEN_FILL |=> state_ff == ST_LEN)
      else $error("length field not started at byte 56");

endmodule
`default_nettype wire

// ===== src/sha1_message_digest.sv =====
// SHA-1 digest: takes big-endian message words, one byte per cycle into a 64-byte
// block while no compression is running. A full word is accepted, its four bytes
// are put, and the controller returns to idle for the next word. Each full block
// then passes through the round unit (load, 80 rounds at one per cycle, chaining
// add). The last word adds its padding and length bytes, one per cycle, and one
// compression (two if fewer than 9 bytes were free). The five digest words h0 to
// h4 are then offered one per cycle while the sink is ready. A new message word is
// taken only when the previous one has been fully consumed and, for a last word,
// its digest fully delivered.
`default_nettype none
module sha1_message_digest import sha1_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   sha1_req_if.sink     req_chan,
   sha1_rsp_if.source   rsp_chan
);

   sha1_cmd_type    cmd;
   sha1_status_type status;
   logic [31:0]     digest_word;

   sha1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sha1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_data     (req_chan.data_word),
      .in_bytes    (req_chan.valid_bytes),
      .in_last     (req_chan.last_word),
      .status      (status),
      .digest_word (digest_word)
   );

   assign rsp_chan.digest_word = digest_word;
   assign rsp_chan.word_index  = cmd.out_idx;
   assign rsp_chan.last_result = (cmd.out_idx == LAST_WORD_IDX);

endmodule
`default_nettype wire

// ===== tb/sv/tb_sha1_if.sv =====
// Testbench item types for message words and digest words.
`timescale 1ns / 100ps
package tb_sha1_types;
   typedef struct {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } msg_word_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_result;
   } digest_item_type;
endpackage

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the streaming SHA-1 digest block.
`timescale 1ns / 100ps
module tb import sha1_pkg::*, tb_sha1_types::*;;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1_req_if req_chan ();
   sha1_rsp_if rsp_chan ();

   sha1_message_digest u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   msg_word_type    pending_words[$];
   digest_item_type digest_expected[$];
   int              error_count = 0;
   int              digests_seen = 0;
   int              words_sent = 0;
   int              messages_sent = 0;
   bit              calm_stretch = 1'b0;
   logic            req_accepted = 1'b0;

   // predictor state
   logic [31:0] chain_h[5];
   logic [31:0] sched_w[16];
   logic [63:0] msg_bits;
   logic [5:0]  fill_bytes;

   function automatic logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic predictor_init();
      chain_h[0] = H_INIT0; chain_h[1] = H_INIT1; chain_h[2] = H_INIT2;
      chain_h[3] = H_INIT3; chain_h[4] = H_INIT4;
      for (int i = 0; i < 16; i++) sched_w[i] = '0;
      msg_bits = '0;
      fill_bytes = '0;
   endtask

   task automatic compress();
      logic [31:0] a, b, c, d, e, f, w, tmp, k;
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            w = rotl(sched_w[(t - 3) & 15] ^ sched_w[(t - 8) & 15] ^
                     sched_w[(t - 14) & 15] ^ sched_w[t & 15], 1);
            sched_w[t & 15] = w;
         end else begin
            w = sched_w[t];
         end
         if (t < 20) begin
            f = (b & c) | (~b & d); k = K_ROUND0;
         end else if (t < 40) begin
            f = b ^ c ^ d; k = K_ROUND1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K_ROUND2;
         end else begin
            f = b ^ c ^ d; k = K_ROUND3;
         end
         tmp = rotl(a, 5) + f + e + w + k;
         e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
   endtask

   task automatic append_byte(logic [7:0] v);
      int idx, sh;
      idx = fill_bytes[5:2];
      sh = 24 - 8 * fill_bytes[1:0];
      sched_w[idx] = (sched_w[idx] & ~(32'hFF << sh)) | (32'(v) << sh);
      fill_bytes = fill_bytes + 6'd1;
   endtask

   task automatic predict_word(msg_word_type m);
      int n;
      digest_item_type r;
      n = (m.valid_bytes > 3'd4) ? 4 : int'(m.valid_bytes);
      for (int i = 0; i < n; i++) begin
         append_byte(m.data_word[31 - 8 * i -: 8]);
         msg_bits += 64'd8;
         if (fill_bytes == 0) compress();
      end
      if (!m.last_word) return;
      append_byte(8'h80);
      if (fill_bytes == 0 || fill_bytes > LEN_FILL) begin
         while (fill_bytes != 0) append_byte(8'h00);
         compress();
      end
      while (fill_bytes < LEN_FILL) append_byte(8'h00);
      sched_w[14] = msg_bits[63:32];
      sched_w[15] = msg_bits[31:0];
      fill_bytes = '0;
      compress();
      for (int i = 0; i < 5; i++) begin
         r.digest_word = chain_h[i];
         r.word_index = 3'(i);
         r.last_result = (3'(i) == LAST_WORD_IDX);
         digest_expected.push_back(r);
      end
      chain_h[0] = H_INIT0; chain_h[1] = H_INIT1; chain_h[2] = H_INIT2;
      chain_h[3] = H_INIT3; chain_h[4] = H_INIT4;
      msg_bits = '0;
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h (digest word %0d)", what, got, want,
               digests_seen);
   endtask

   function automatic bit idle_now();
      return !calm_stretch && ($urandom_range(99) < 17);
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   initial begin
      req_chan.valid = 1'b0;
      req_chan.data_word = '0;
      req_chan.valid_bytes = '0;
      req_chan.last_word = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_accepted) begin
         if (pending_words.size() > 0 && !idle_now()) begin
            msg_word_type m;
            m = pending_words.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.data_word <= m.data_word;
            req_chan.valid_bytes <= m.valid_bytes;
            req_chan.last_word <= m.last_word;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_accepted <= 1'b0;
      if (!reset && req_chan.valid && req_chan.ready) begin
         msg_word_type m;
         m.data_word = req_chan.data_word;
         m.valid_bytes = req_chan.valid_bytes;
         m.last_word = req_chan.last_word;
         predict_word(m);
         words_sent++;
         req_accepted <= 1'b1;
      end
   end

   // monitor
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) rsp_chan.ready <= reset ? 1'b0 : !idle_now();

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         digest_item_type want;
         digests_seen++;
         if (digest_expected.size() == 0) begin
            report("unexpected digest word", rsp_chan.digest_word, 32'h0);
         end else begin
            want = digest_expected.pop_front();
            if (rsp_chan.digest_word !== want.digest_word)
               report("digest_word", rsp_chan.digest_word, want.digest_word);
            if (rsp_chan.word_index !== want.word_index)
               report("word_index", 32'(rsp_chan.word_index), 32'(want.word_index));
            if (rsp_chan.last_result !== want.last_result)
               report("last_result", 32'(rsp_chan.last_result), 32'(want.last_result));
         end
      end
   end

   task automatic queue_word(logic [31:0] d, logic [2:0] nb, logic lst);
      msg_word_type m;
      m.data_word = d; m.valid_bytes = nb; m.last_word = lst;
      pending_words.push_back(m);
      if (lst) messages_sent++;
   endtask

   // message of n full words, closed by a last word of tail_bytes bytes
   task automatic queue_message(int n, logic [2:0] tail_bytes);
      for (int i = 0; i < n; i++) queue_word($urandom(), 3'd4, 1'b0);
      queue_word($urandom(), tail_bytes, 1'b1);
   endtask

   initial begin
      predictor_init();
      // directed: empty message, "abc", field extremes, padding boundaries
      queue_word(32'h0, 3'd0, 1'b1);
      queue_word(32'h61626300, 3'd3, 1'b1);
      queue_word(32'hFFFFFFFF, 3'd4, 1'b1);
      queue_word(32'h00000000, 3'd7, 1'b1);
      queue_word(32'hA5A5A5A5, 3'd2, 1'b0);       // short word inside message
      queue_word(32'h5A5A5A5A, 3'd5, 1'b0);       // count above four
      queue_word(32'h12345678, 3'd1, 1'b1);
      queue_message(13, 3'd3);                    // 55 bytes: length fits
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      queue_message(13, 3'd4);                    // 56 bytes: extra block
      queue_message(15, 3'd0);                    // 60 bytes, empty last
      queue_message(15, 3'd4);                    // exactly 64 bytes
      // random: mostly well-formed messages, some odd words
      while (words_sent + pending_words.size() < 350) begin
         int n;
         n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(20);
         if ($urandom_range(4) == 0)
            queue_word($urandom(), 3'($urandom_range(7)), 1'b0);
         queue_message(n, 3'($urandom_range(7)));
         wait (pending_words.size() < 8);
         calm_stretch = (messages_sent % 10) < 2;
      end
      wait (pending_words.size() == 0 && !req_chan.valid);
      wait (digest_expected.size() == 0);
      repeat (300) @(posedge clock);
      $display("tb: %0d message words in %0d messages, %0d digest words checked",
               words_sent, messages_sent, digests_seen);
      if (error_count == 0 && digest_expected.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: FAIL");
      $finish;
   end
endmodule
